@@ design/etct_pkg.sv @@
`timescale 1ns / 1ps
// Package for the energy threshold crossing time block.
// Sequencer states, register map and fixed field widths; no dependencies.
package etct_pkg;

   localparam int TIME_W   = 32;
   localparam int ENERGY_W = 24;
   localparam int THRESH_W = 30;
   localparam int KEY_W    = TIME_W + ENERGY_W;

   // result time when the set held no segments
   localparam logic [TIME_W-1:0] HIT_TIME_EMPTY = 32'h7FFF_FFFF;

   // register map, word index
   localparam logic CSR_ENERGY_THRESHOLD = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_PUSH
   } seq_state_type;

endpackage

@@ design/energy_threshold_crossing_time.sv @@
`timescale 1ns / 1ps
// Energy threshold crossing time: insertion-sorted segment store and ordered scan.
// Depends on etct_pkg.
//
// Usage:
//  req_* stream carries one deposit segment per word (time, energy); tuser marks a
//  word that really holds a segment, tlast closes the set and starts the scan.
//  rsp_* stream returns one word per closed set: crossing time and three flags.
//  csr_* APB port holds energy_threshold at byte address 0.
// Operation:
//  A word with no segment leaves the sequencer in ST_IDLE unless it closes the set.
//  A stored segment is placed by insertion into one single-port-write, registered-read
//  memory: ST_INS_RD reads the entry below it and ST_INS_CMP moves that entry up, until
//  one of them writes the segment in place. The scan after tlast reads that memory in
//  order, ST_SCAN_RD then ST_SCAN_CHK per segment, until the sum crosses or the last
//  is checked; ST_PUSH then loads the output register (an empty set skips ST_SCAN_CHK).
//  Segments beyond MAX_SEGMENTS are dropped and flagged in the result.
// Reset clears the count, overflow flag, rsp_tvalid and threshold; not the memory.
// req_tready is low while a segment is placed, a set is scanned or its result is
// pushed. A stalled result waits in the output register; further segments are
// accepted meanwhile, and the next set's result waits until the previous one is taken.
module energy_threshold_crossing_time
   import etct_pkg::*;
#(
   parameter int MAX_SEGMENTS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // segment input
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [55:0]           req_tdata,   // [31:0] seg_time, [55:32] seg_energy
   input  logic                  req_tuser,   // [0] has_segment
   input  logic                  req_tlast,   // last_segment
   // result output
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,   // [31:0] hit_time
   output logic [2:0]            rsp_tuser,   // [0] crossed, [1] empty_set, [2] overflowed
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int IDX_W  = $clog2(MAX_SEGMENTS);
   localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
   localparam int SUM_W  = ENERGY_W + IDX_W;
   localparam int CMP_W  = (SUM_W > THRESH_W) ? SUM_W : THRESH_W;

   seq_state_type state_ff, state_in;

   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                ovf_ff, ovf_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                last_ff, last_in;
   logic [KEY_W-1:0]    new_key_ff, new_key_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [TIME_W-1:0]   res_time_ff, res_time_in;
   logic                res_crossed_ff, res_crossed_in;
   logic [THRESH_W-1:0] thr_ff, thr_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0]   rsp_time_ff, rsp_time_in;
   logic                rsp_crossed_ff, rsp_crossed_in;
   logic                rsp_empty_ff, rsp_empty_in;
   logic                rsp_ovf_ff, rsp_ovf_in;

   // segment store: key is {time with sign flipped, energy}, so unsigned order
   // of the key is the segment order
   logic [KEY_W-1:0]    seg_mem [MAX_SEGMENTS];
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr, mem_raddr;
   logic [KEY_W-1:0]    mem_wdata, rd_data_ff;

   logic                req_fire, csr_wr, room, new_before, crosses, at_last, go_scan;
   logic [SUM_W-1:0]    sum_nxt;
   logic [TIME_W-1:0]   rd_time;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign room       = (cnt_ff < CNT_W'(MAX_SEGMENTS));
   assign new_before = (new_key_ff < rd_data_ff);
   assign sum_nxt    = sum_ff + SUM_W'(rd_data_ff[ENERGY_W-1:0]);
   assign crosses    = (CMP_W'(sum_nxt) > CMP_W'(thr_ff));
   assign at_last    = ((CNT_W'(idx_ff) + CNT_W'(1)) == cnt_ff);
   assign rd_time    = {~rd_data_ff[KEY_W-1], rd_data_ff[KEY_W-2:ENERGY_W]};
   assign go_scan    = (state_in == ST_SCAN_RD) && (state_ff != ST_SCAN_CHK);

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_ENERGY_THRESHOLD) ?
                       {{(32 - THRESH_W){1'b0}}, thr_ff} : 32'h0;
   assign thr_in     = (csr_wr && (csr_paddr[2] == CSR_ENERGY_THRESHOLD)) ?
                       csr_pwdata[THRESH_W-1:0] : thr_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_time_ff;
   assign rsp_tuser  = {rsp_ovf_ff, rsp_empty_ff, rsp_crossed_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser && room) state_in = ST_INS_RD;
               else if (req_tlast)    state_in = ST_SCAN_RD;
            end
         end
         ST_INS_RD: begin
            if (idx_ff == '0) state_in = last_ff ? ST_SCAN_RD : ST_IDLE;
            else              state_in = ST_INS_CMP;
         end
         ST_INS_CMP: begin
            if (new_before) state_in = ST_INS_RD;
            else            state_in = last_ff ? ST_SCAN_RD : ST_IDLE;
         end
         ST_SCAN_RD: begin
            state_in = (cnt_ff == '0) ? ST_PUSH : ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            state_in = (crosses || at_last) ? ST_PUSH : ST_SCAN_RD;
         end
         ST_PUSH: begin
            if (!rsp_valid_ff) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      cnt_in         = cnt_ff;
      ovf_in         = ovf_ff;
      idx_in         = idx_ff;
      last_in        = last_ff;
      new_key_in     = new_key_ff;
      sum_in         = sum_ff;
      res_time_in    = res_time_ff;
      res_crossed_in = res_crossed_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_time_in    = rsp_time_ff;
      rsp_crossed_in = rsp_crossed_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      mem_we         = 1'b0;
      mem_waddr      = idx_ff;
      mem_wdata      = new_key_ff;
      mem_raddr      = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               new_key_in = {~req_tdata[31], req_tdata[30:0], req_tdata[55:32]};
               idx_in     = cnt_ff[IDX_W-1:0];
               last_in    = req_tlast;
               if (req_tuser && !room) ovf_in = 1'b1;
            end
         end
         ST_INS_RD: begin
            if (idx_ff == '0) begin
               mem_we = 1'b1;
               cnt_in = cnt_ff + CNT_W'(1);
            end else begin
               mem_raddr = idx_ff - IDX_W'(1);
            end
         end
         ST_INS_CMP: begin
            mem_we = 1'b1;
            if (new_before) begin
               // move the larger entry up one slot
               mem_wdata = rd_data_ff;
               idx_in    = idx_ff - IDX_W'(1);
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_SCAN_RD: begin
            if (cnt_ff == '0) begin
               res_time_in    = HIT_TIME_EMPTY;
               res_crossed_in = 1'b0;
            end
         end
         ST_SCAN_CHK: begin
            if (crosses) begin
               res_time_in    = rd_time;
               res_crossed_in = 1'b1;
            end else if (at_last) begin
               res_time_in    = rd_time;
               res_crossed_in = 1'b0;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
               sum_in = sum_nxt;
            end
         end
         ST_PUSH: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in   = 1'b1;
               rsp_time_in    = res_time_ff;
               rsp_crossed_in = res_crossed_ff;
               rsp_empty_in   = (cnt_ff == '0);
               rsp_ovf_in     = ovf_ff;
               cnt_in         = '0;
               ovf_in         = 1'b0;
            end
         end
         default: ;
      endcase
      if (go_scan) begin
         idx_in = '0;
         sum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         thr_ff       <= thr_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      last_ff        <= last_in;
      new_key_ff     <= new_key_in;
      sum_ff         <= sum_in;
      res_time_ff    <= res_time_in;
      res_crossed_ff <= res_crossed_in;
      rsp_time_ff    <= rsp_time_in;
      rsp_crossed_ff <= rsp_crossed_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_ovf_ff     <= rsp_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) seg_mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= seg_mem[mem_raddr];
   end

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_SEGMENTS))
      else $error("segment count above capacity");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> (!rsp_tuser[0] && rsp_tdata == HIT_TIME_EMPTY))
      else $error("empty set result malformed");

   a_busy_after_close: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> !req_tready)
      else $error("input taken while a closed set is pending");

   a_push_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH && rsp_valid_ff && !rsp_tready) |=> state_ff == ST_PUSH)
      else $error("result dropped while output stalled");
`endif

endmodule
